@@ rtl/fdc_pkg.sv @@
// shared types and constants of the fenwick dominance counter
package fdc_pkg;

   // tree and accumulator geometry
   localparam int ROW_COUNT   = 1024;
   localparam int QUERY_COUNT = 256;
   localparam int ROW_W       = $clog2(ROW_COUNT);
   localparam int QUERY_W     = $clog2(QUERY_COUNT);
   localparam int POS_W       = ROW_W + 2;

   // transaction field widths
   localparam int CMD_W      = 2;
   localparam int ROW_IN_W   = 11;
   localparam int QIDX_W     = 8;
   localparam int COUNT_W    = 20;
   localparam int ACC_W      = 22;
   localparam int ACC_EXT_W  = ACC_W + 1;

   // saturation limits
   localparam logic [COUNT_W-1:0] ENTRY_MAX = {COUNT_W{1'b1}};
   localparam logic signed [ACC_EXT_W-1:0] ACC_MAX = ACC_EXT_W'((1 << (ACC_W - 1)) - 1);
   localparam logic signed [ACC_EXT_W-1:0] ACC_MIN = -ACC_EXT_W'(1 << (ACC_W - 1));

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_SUB    = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INSERT,
      ST_QUERY,
      ST_UPDATE
   } state_type;

endpackage

@@ rtl/fdc_req_if.sv @@
// event channel: command, row and query index with valid/ready
interface fdc_req_if;
   logic                          valid;
   logic                          ready;
   logic [fdc_pkg::CMD_W-1:0]     command;
   logic [fdc_pkg::ROW_IN_W-1:0]  row;
   logic [fdc_pkg::QIDX_W-1:0]    query_index;

   modport source (output valid, output command, output row, output query_index,
                   input ready);
   modport sink   (input valid, input command, input row, input query_index,
                   output ready);
endinterface

@@ rtl/fdc_rsp_if.sv @@
// result channel: query tag, prefix count and running answer with valid/ready
interface fdc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [fdc_pkg::QIDX_W-1:0]          query_tag;
   logic [fdc_pkg::COUNT_W-1:0]         prefix_count;
   logic signed [fdc_pkg::ACC_W-1:0]    running_answer;

   modport source (output valid, output query_tag, output prefix_count,
                   output running_answer, input ready);
   modport sink   (input valid, input query_tag, input prefix_count,
                   input running_answer, output ready);
endinterface

@@ rtl/fenwick_dominance_counter_top.sv @@
// top level: binary indexed tree sweep counter with per-query accumulators
// walk length: an insert walks at most 11 tree entries, a query at most 10
// throughput: one event at a time, one tree entry per cycle sets the walk rate
// reset: synchronous, clears control state, then a clearing pass zeroes the
//   tree and the accumulators while no event is taken
module fenwick_dominance_counter_top (
   input logic          clock,
   input logic          reset,
   fdc_req_if.sink      req_bus,
   fdc_rsp_if.source    rsp_bus
);

   // sequencer state
   fdc_pkg::state_type                  state_ff, state_in;
   logic [fdc_pkg::ROW_W-1:0]           clr_cnt_ff, clr_cnt_in;

   // event being worked on
   fdc_pkg::command_type                cmd_ff, cmd_in;
   logic [fdc_pkg::QUERY_W-1:0]         qidx_ff, qidx_in;
   logic [fdc_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic                                pend_ff, pend_in;
   logic [fdc_pkg::ROW_W-1:0]           waddr_ff, waddr_in;
   logic [fdc_pkg::COUNT_W-1:0]         total_ff, total_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fdc_pkg::QIDX_W-1:0]          tag_ff, tag_in;
   logic [fdc_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic signed [fdc_pkg::ACC_W-1:0]    answer_ff, answer_in;

   // memories and their ports
   logic [fdc_pkg::COUNT_W-1:0]         tree_mem [fdc_pkg::ROW_COUNT];
   logic signed [fdc_pkg::ACC_W-1:0]    acc_mem  [fdc_pkg::QUERY_COUNT];
   logic [fdc_pkg::COUNT_W-1:0]         tree_rdata_ff;
   logic signed [fdc_pkg::ACC_W-1:0]    acc_rdata_ff;
   logic                                tree_we;
   logic [fdc_pkg::ROW_W-1:0]           tree_waddr;
   logic [fdc_pkg::COUNT_W-1:0]         tree_wdata;
   logic [fdc_pkg::ROW_W-1:0]           tree_raddr;
   logic                                acc_we;
   logic [fdc_pkg::QUERY_W-1:0]         acc_waddr;
   logic signed [fdc_pkg::ACC_W-1:0]    acc_wdata;

   // datapath helpers
   logic [fdc_pkg::POS_W-1:0]           low_bit;
   logic [fdc_pkg::POS_W-1:0]           pos_dec;
   logic [fdc_pkg::POS_W-1:0]           row_ext;
   logic                                pos_in_range;
   logic [fdc_pkg::COUNT_W:0]           total_sum;
   logic signed [fdc_pkg::ACC_EXT_W-1:0] acc_ext;
   logic signed [fdc_pkg::ACC_EXT_W-1:0] cnt_ext;
   logic signed [fdc_pkg::ACC_EXT_W-1:0] acc_sum;
   logic signed [fdc_pkg::ACC_W-1:0]    acc_sat;
   logic                                req_fire;
   logic                                rsp_free;

   assign low_bit      = pos_ff & (~pos_ff + fdc_pkg::POS_W'(1));
   assign pos_dec      = pos_ff - fdc_pkg::POS_W'(1);
   assign row_ext      = fdc_pkg::POS_W'(req_bus.row);
   assign pos_in_range = (pos_ff != '0) &&
                         (pos_ff <= fdc_pkg::POS_W'(fdc_pkg::ROW_COUNT));
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;

   // saturating prefix accumulate, one tree entry per cycle
   assign total_sum = {1'b0, total_ff} + {1'b0, tree_rdata_ff};

   // signed accumulator update with clamp to the 22-bit range
   assign acc_ext = fdc_pkg::ACC_EXT_W'(acc_rdata_ff);
   assign cnt_ext = $signed({{(fdc_pkg::ACC_EXT_W - fdc_pkg::COUNT_W){1'b0}}, total_ff});
   assign acc_sum = (cmd_ff == fdc_pkg::CMD_SUB) ? acc_ext - cnt_ext : acc_ext + cnt_ext;
   always_comb begin
      if (acc_sum > fdc_pkg::ACC_MAX) begin
         acc_sat = fdc_pkg::ACC_W'(fdc_pkg::ACC_MAX);
      end else if (acc_sum < fdc_pkg::ACC_MIN) begin
         acc_sat = fdc_pkg::ACC_W'(fdc_pkg::ACC_MIN);
      end else begin
         acc_sat = acc_sum[fdc_pkg::ACC_W-1:0];
      end
   end

   // sequencer: next state, memory controls and result load
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cmd_in       = cmd_ff;
      qidx_in      = qidx_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      waddr_in     = waddr_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      tag_in       = tag_ff;
      count_in     = count_ff;
      answer_in    = answer_ff;
      tree_we      = 1'b0;
      tree_waddr   = waddr_ff;
      tree_wdata   = (tree_rdata_ff == fdc_pkg::ENTRY_MAX) ? tree_rdata_ff :
                     tree_rdata_ff + fdc_pkg::COUNT_W'(1);
      tree_raddr   = pos_dec[fdc_pkg::ROW_W-1:0];
      acc_we       = 1'b0;
      acc_waddr    = qidx_ff;
      acc_wdata    = acc_sat;
      req_bus.ready = 1'b0;

      unique case (state_ff)
         fdc_pkg::ST_CLEAR: begin
            // zero one tree entry per cycle, and one accumulator while the count is below 256
            tree_we    = 1'b1;
            tree_waddr = clr_cnt_ff;
            tree_wdata = '0;
            acc_we     = (int'(clr_cnt_ff) < fdc_pkg::QUERY_COUNT);
            acc_waddr  = clr_cnt_ff[fdc_pkg::QUERY_W-1:0];
            acc_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + fdc_pkg::ROW_W'(1);
            if (clr_cnt_ff == fdc_pkg::ROW_W'(fdc_pkg::ROW_COUNT - 1)) begin
               state_in = fdc_pkg::ST_IDLE;
            end
         end
         fdc_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               cmd_in   = fdc_pkg::command_type'(req_bus.command);
               qidx_in  = req_bus.query_index[fdc_pkg::QUERY_W-1:0];
               total_in = '0;
               case (fdc_pkg::command_type'(req_bus.command))
                  fdc_pkg::CMD_INSERT: begin
                     pos_in   = row_ext;
                     state_in = fdc_pkg::ST_INSERT;
                  end
                  fdc_pkg::CMD_ADD, fdc_pkg::CMD_SUB: begin
                     // rows past the top cover the whole tree
                     pos_in   = (row_ext > fdc_pkg::POS_W'(fdc_pkg::ROW_COUNT)) ?
                                fdc_pkg::POS_W'(fdc_pkg::ROW_COUNT) : row_ext;
                     state_in = fdc_pkg::ST_QUERY;
                  end
                  default: begin
                     state_in = fdc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         fdc_pkg::ST_INSERT: begin
            // write back the entry read last cycle while reading the next one
            tree_we = pend_ff;
            if (pos_in_range) begin
               pend_in  = 1'b1;
               waddr_in = pos_dec[fdc_pkg::ROW_W-1:0];
               pos_in   = pos_ff + low_bit;
            end else begin
               state_in = fdc_pkg::ST_IDLE;
            end
         end
         fdc_pkg::ST_QUERY: begin
            if (pend_ff) begin
               total_in = total_sum[fdc_pkg::COUNT_W] ? fdc_pkg::ENTRY_MAX :
                          total_sum[fdc_pkg::COUNT_W-1:0];
            end
            if (pos_ff != '0) begin
               pend_in = 1'b1;
               pos_in  = pos_ff - low_bit;
            end else begin
               state_in = fdc_pkg::ST_UPDATE;
            end
         end
         fdc_pkg::ST_UPDATE: begin
            // hold until the result register is free
            if (rsp_free) begin
               acc_we       = 1'b1;
               rsp_valid_in = 1'b1;
               tag_in       = fdc_pkg::QIDX_W'(qidx_ff);
               count_in     = total_ff;
               answer_in    = acc_sat;
               state_in     = fdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdc_pkg::ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdc_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      qidx_ff   <= qidx_in;
      pos_ff    <= pos_in;
      waddr_ff  <= waddr_in;
      total_ff  <= total_in;
      tag_ff    <= tag_in;
      count_ff  <= count_in;
      answer_ff <= answer_in;
   end

   // tree memory: at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr] <= tree_wdata;
      end
      tree_rdata_ff <= tree_mem[tree_raddr];
   end

   // accumulator memory: read address follows the current query
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rdata_ff <= acc_mem[qidx_ff];
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.query_tag      = tag_ff;
   assign rsp_bus.prefix_count   = count_ff;
   assign rsp_bus.running_answer = answer_ff;

`ifndef SYNTHESIS
   // no transaction is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdc_pkg::ST_CLEAR) |-> !req_fire)
      else $error("event accepted while clearing");

   // an accumulator write outside the clearing pass always presents a result
   assert property (@(posedge clock) disable iff (reset)
      (acc_we && state_ff == fdc_pkg::ST_UPDATE) |=> rsp_valid_ff)
      else $error("accumulator updated without a result");

   // the downward walk never moves up
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdc_pkg::ST_QUERY && $past(state_ff) == fdc_pkg::ST_QUERY)
      |-> (pos_ff < $past(pos_ff)))
      else $error("query walk did not descend");

   // tree writes outside the clearing pass come only from the insert walk
   assert property (@(posedge clock) disable iff (reset)
      (tree_we && state_ff != fdc_pkg::ST_CLEAR) |-> (cmd_ff == fdc_pkg::CMD_INSERT))
      else $error("tree written by a query");
`endif

endmodule
